// ----- sv/tte_pkg.sv -----
// Package for the text terminal escape engine: beat types, parser phase codes,
// character constants and the decimal parameter accumulator. No dependencies.
package tte_pkg;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 7;
    localparam int PARAM_W = 14;

    localparam logic [PARAM_W-1:0] PARAM_MAX = 14'd9999;
    localparam logic [4:0]         SCROLL_RESET = 5'd24;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;

    typedef enum logic [4:0] {
        PH_GROUND = 5'b00001,
        PH_ESC    = 5'b00010,
        PH_FIRST  = 5'b00100,
        PH_SECOND = 5'b01000,
        PH_SKIP   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       func;
        logic [7:0] stream_byte;
        logic       end_of_chunk;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic [7:0] cell_char;
    } out_beat_t;

    typedef struct packed {
        phase_t             phase;
        logic [PARAM_W-1:0] first_param;
        logic [PARAM_W-1:0] second_param;
        logic               second_seen;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               wr_en;
        logic [7:0]         wr_data;
        cmd_t               cmd;
        logic [PARAM_W-1:0] count;
    } parse_res_t;

    function automatic logic [PARAM_W-1:0] add_digit(input logic [PARAM_W-1:0] acc,
                                                      input logic [7:0] c);
        logic [17:0] sum;
        begin
            sum = 18'({acc, 3'b000}) + 18'({acc, 1'b0}) + 18'(c - CH_0);
            add_digit = (sum > 18'(PARAM_MAX)) ? PARAM_MAX : sum[PARAM_W-1:0];
        end
    endfunction

endpackage

// ----- sv/tte_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3200,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/tte_parse.sv -----
// Byte decoder of the escape parser: next phase, parameters, cursor and the
// cell write of one stream byte. Depends on tte_pkg.
module tte_parse #(
    parameter int TEXT_ROWS = 24,
    parameter int TEXT_COLS = 80
) (
    input  logic [7:0]                   stream_byte,
    input  logic                         end_of_chunk,
    input  tte_pkg::phase_t              phase,
    input  logic [tte_pkg::PARAM_W-1:0]  first_param,
    input  logic [tte_pkg::PARAM_W-1:0]  second_param,
    input  logic                         second_seen,
    input  logic [tte_pkg::ROW_W-1:0]    row,
    input  logic [tte_pkg::COL_W-1:0]    col,
    output tte_pkg::parse_res_t          res
);
    import tte_pkg::*;

    localparam logic [ROW_W-1:0]   TR  = ROW_W'(TEXT_ROWS);
    localparam logic [COL_W-1:0]   TC  = COL_W'(TEXT_COLS);

    logic               digit;
    logic               letter;
    logic               plain;
    logic               run;
    logic [PARAM_W-1:0] n;
    logic [PARAM_W-1:0] v;
    logic [PARAM_W:0]   csum;

    always_comb
    begin
        digit  = (stream_byte >= CH_0) && (stream_byte <= CH_9);
        letter = ((stream_byte >= 8'h41) && (stream_byte <= 8'h5A))
              || ((stream_byte >= 8'h61) && (stream_byte <= 8'h7A));
        plain  = 1'b0;
        run    = 1'b0;
        res.phase        = phase;
        res.first_param  = first_param;
        res.second_param = second_param;
        res.second_seen  = second_seen;
        res.row          = row;
        res.col          = col;
        res.wr_en        = 1'b0;
        res.wr_data      = (stream_byte == CH_NUL) ? CH_SPACE : stream_byte;
        res.cmd          = CMD_NONE;
        n                = (first_param == '0) ? PARAM_W'(1) : first_param;
        res.count        = n;
        v                = '0;
        csum             = '0;

        case (phase)
            PH_ESC:
            begin
                if (stream_byte == CH_LBRK)
                begin
                    res.first_param  = '0;
                    res.second_param = '0;
                    res.second_seen  = 1'b0;
                    res.phase        = PH_FIRST;
                end
                else if (stream_byte == CH_ESC)
                begin
                    res.phase = PH_ESC;
                end
                else
                begin
                    res.phase = PH_GROUND;
                    plain     = 1'b1;
                end
            end
            PH_FIRST:
            begin
                if (digit)
                begin
                    res.first_param = add_digit(first_param, stream_byte);
                end
                else if (stream_byte == CH_SEMI)
                begin
                    res.second_seen = 1'b1;
                    res.phase       = PH_SECOND;
                end
                else
                begin
                    run = 1'b1;
                end
            end
            PH_SECOND:
            begin
                if (digit)
                begin
                    res.second_param = add_digit(second_param, stream_byte);
                end
                else
                begin
                    run = 1'b1;
                end
            end
            PH_SKIP:
            begin
                run = 1'b1;
            end
            default:
            begin
                if (stream_byte == CH_ESC)
                begin
                    res.phase = PH_ESC;
                end
                else
                begin
                    res.phase = PH_GROUND;
                    plain     = 1'b1;
                end
            end
        endcase

        // Final byte: a letter runs the command, anything else is skipped.
        if (run)
        begin
            if (letter)
            begin
                res.phase = PH_GROUND;
                if (stream_byte == CH_H)
                begin
                    v = (first_param == '0) ? '0 : first_param - PARAM_W'(1);
                    res.row = (v > PARAM_W'(TR)) ? TR : v[ROW_W-1:0];
                    v = second_seen ? second_param : PARAM_W'(1);
                    v = (v == '0) ? '0 : v - PARAM_W'(1);
                    res.col = (v > PARAM_W'(TC)) ? TC : v[COL_W-1:0];
                end
                else if (stream_byte == CH_C)
                begin
                    csum = (PARAM_W+1)'(col) + (PARAM_W+1)'(n);
                    res.col = (csum > (PARAM_W+1)'(TC)) ? TC : csum[COL_W-1:0];
                end
                else if (stream_byte == CH_D)
                begin
                    res.col = (n >= PARAM_W'(col)) ? '0 : col - n[COL_W-1:0];
                end
                else if (stream_byte == CH_K)
                begin
                    res.cmd = CMD_ERASE;
                end
                else if (stream_byte == CH_L)
                begin
                    res.cmd = CMD_INSERT;
                end
                else if (stream_byte == CH_M)
                begin
                    res.cmd = CMD_DELETE;
                end
            end
            else
            begin
                res.phase = PH_SKIP;
            end
        end

        if (plain)
        begin
            if (stream_byte == CH_CR)
            begin
                res.col = '0;
            end
            else if (stream_byte == CH_LF)
            begin
                if (row < TR)
                begin
                    res.row = row + ROW_W'(1);
                end
                res.col = '0;
            end
            else if (col < TC)
            begin
                res.wr_en = 1'b1;
                res.col   = col + COL_W'(1);
            end
        end

        if (end_of_chunk)
        begin
            res.phase = PH_GROUND;
        end
    end
endmodule

// ----- sv/text_terminal_escape_engine_top.sv -----
// Top level of the text terminal escape engine: sequencer, cursor and parser
// registers, and the screen RAM. Depends on tte_pkg, tte_parse and tte_ram.
//
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries one beat per
//   stream byte (func = 0) or cell read query (func = 1). Each accepted beat
//   yields exactly one output beat on out_valid / out_stall / out_data with
//   the cursor position after the beat and, for a query, the cell character.
//   For plain bytes, cursor moves and parameter bytes the result is
//   registered and shows the cycle after acceptance. A read query is read
//   through the registered RAM read port, and ST_RD_WAIT registers the result.
//   Erase to end of line writes one cell a cycle, TEXT_COLS - col cells.
//   Line insert/delete copies each moved cell by a read and a write-back
//   state, blanks the vacated rows one cell a cycle, all through the
//   single screen RAM; in_stall stays high meanwhile.
//   After reset the RAM is swept to spaces, one cell a cycle over all
//   (TEXT_ROWS + 1) * 128 cells, with in_stall high; the scroll region
//   register may be written during this sweep.
//   When out_stall holds a result, a new beat is taken only in the cycle the
//   pending result leaves.
module text_terminal_escape_engine_top #(
    parameter int TEXT_ROWS = 24,
    parameter int TEXT_COLS = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tte_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tte_pkg::out_beat_t out_data,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data
);
    import tte_pkg::*;

    // Cells live at row * 128 + col.
    localparam int DEPTH = (TEXT_ROWS + 1) * 128;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [ROW_W-1:0] TR   = ROW_W'(TEXT_ROWS);
    localparam logic [COL_W-1:0] TC   = COL_W'(TEXT_COLS);
    localparam logic [COL_W-1:0] LASTC = COL_W'(TEXT_COLS - 1);
    localparam logic [AW-1:0]    LASTA = AW'(DEPTH - 1);

    typedef enum logic [7:0] {
        ST_INIT    = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_RD_WAIT = 8'b0000_0100,
        ST_ERASE   = 8'b0000_1000,
        ST_COPY_RD = 8'b0001_0000,
        ST_COPY_WR = 8'b0010_0000,
        ST_BLANK   = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg;
    logic [PARAM_W-1:0] first_reg, second_reg;
    logic               seen_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [4:0]         scroll_reg;

    logic [AW-1:0]      init_reg, init_next;
    logic [COL_W-1:0]   ptr_reg, ptr_next;
    logic [ROW_W-1:0]   dst_reg, dst_next;
    logic [ROW_W-1:0]   src_reg, src_next;
    logic [ROW_W-1:0]   blank_reg, blank_next;
    logic [COL_W-1:0]   copies_reg, copies_next;
    logic [COL_W-1:0]   blanks_reg, blanks_next;
    logic               down_reg, down_next;
    logic               rd_ok_reg;

    logic               out_valid_reg;
    out_beat_t          out_reg;

    parse_res_t         pr;
    logic               accept;
    logic               take_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    // Line shift setup
    logic [ROW_W-1:0]   last_row;
    logic [COL_W-1:0]   span;
    logic [COL_W-1:0]   cnt;

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        logic [ROW_W+COL_W-1:0] a;
        begin
            a = {r, c};
            cell_addr = a[AW-1:0];
        end
    endfunction

    tte_parse #(
        .TEXT_ROWS (TEXT_ROWS),
        .TEXT_COLS (TEXT_COLS)
    ) u_parse (
        .stream_byte  (in_data.stream_byte),
        .end_of_chunk (in_data.end_of_chunk),
        .phase        (phase_reg),
        .first_param  (first_reg),
        .second_param (second_reg),
        .second_seen  (seen_reg),
        .row          (row_reg),
        .col          (col_reg),
        .res          (pr)
    );

    tte_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign take_out  = out_valid_reg && !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Region bounds for line insert/delete, from the cursor row.
    always_comb
    begin
        if ({1'b0, row_reg} < (ROW_W+1)'(scroll_reg))
        begin
            last_row = ROW_W'(scroll_reg - 5'd1);
        end
        else
        begin
            last_row = TR;
        end
        if (last_row > TR)
        begin
            last_row = TR;
        end
        span = COL_W'(last_row) - COL_W'(row_reg) + COL_W'(1);
        cnt  = (pr.count > PARAM_W'(span)) ? span : pr.count[COL_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        ptr_next    = ptr_reg;
        dst_next    = dst_reg;
        src_next    = src_reg;
        blank_next  = blank_reg;
        copies_next = copies_reg;
        blanks_next = blanks_reg;
        down_next   = down_reg;
        ram_we      = 1'b0;
        ram_waddr   = cell_addr(row_reg, col_reg);
        ram_wdata   = CH_SPACE;
        ram_raddr   = cell_addr(src_reg, ptr_reg);

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_reg;
                init_next = init_reg + AW'(1);
                if (init_reg == LASTA)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = cell_addr(ROW_W'(in_data.read_row), in_data.read_col);
                if (accept)
                begin
                    if (in_data.func)
                    begin
                        state_next = ST_RD_WAIT;
                    end
                    else
                    begin
                        ram_we    = pr.wr_en;
                        ram_wdata = pr.wr_data;
                        ptr_next  = '0;
                        case (pr.cmd)
                            CMD_ERASE:
                            begin
                                ptr_next   = col_reg;
                                state_next = (col_reg < TC) ? ST_ERASE : ST_FINISH;
                            end
                            CMD_INSERT:
                            begin
                                down_next   = 1'b1;
                                dst_next    = last_row;
                                src_next    = last_row - ROW_W'(cnt);
                                blank_next  = row_reg;
                                copies_next = span - cnt;
                                blanks_next = cnt;
                                state_next  = (span == cnt) ? ST_BLANK : ST_COPY_RD;
                            end
                            CMD_DELETE:
                            begin
                                down_next   = 1'b0;
                                dst_next    = row_reg;
                                src_next    = row_reg + ROW_W'(cnt);
                                blank_next  = last_row - ROW_W'(cnt) + ROW_W'(1);
                                copies_next = span - cnt;
                                blanks_next = cnt;
                                state_next  = (span == cnt) ? ST_BLANK : ST_COPY_RD;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_ERASE:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(row_reg, ptr_reg);
                ptr_next  = ptr_reg + COL_W'(1);
                if (ptr_reg == LASTC)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                // Write back the cell read last cycle, then advance.
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(dst_reg, ptr_reg);
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg + COL_W'(1);
                state_next = ST_COPY_RD;
                if (ptr_reg == LASTC)
                begin
                    ptr_next    = '0;
                    copies_next = copies_reg - COL_W'(1);
                    dst_next    = down_reg ? dst_reg - ROW_W'(1) : dst_reg + ROW_W'(1);
                    src_next    = down_reg ? src_reg - ROW_W'(1) : src_reg + ROW_W'(1);
                    if (copies_reg == COL_W'(1))
                    begin
                        state_next = ST_BLANK;
                    end
                end
            end
            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(blank_reg, ptr_reg);
                ptr_next  = ptr_reg + COL_W'(1);
                if (ptr_reg == LASTC)
                begin
                    ptr_next    = '0;
                    blank_next  = blank_reg + ROW_W'(1);
                    blanks_next = blanks_reg - COL_W'(1);
                    if (blanks_reg == COL_W'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_reg      <= '0;
            phase_reg     <= PH_GROUND;
            first_reg     <= '0;
            second_reg    <= '0;
            seen_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            scroll_reg    <= SCROLL_RESET;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            copies_reg    <= '0;
            blanks_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            ptr_reg    <= ptr_next;
            copies_reg <= copies_next;
            blanks_reg <= blanks_next;
            if (cfg_wr_en)
            begin
                scroll_reg <= cfg_wr_data;
            end

            if (accept && !in_data.func)
            begin
                phase_reg  <= pr.phase;
                first_reg  <= pr.first_param;
                second_reg <= pr.second_param;
                seen_reg   <= pr.second_seen;
                row_reg    <= pr.row;
                col_reg    <= pr.col;
            end

            // Result beat: load on a finished item, drop once taken.
            if ((accept && !in_data.func && (pr.cmd == CMD_NONE))
                || (state_reg == ST_RD_WAIT) || (state_reg == ST_FINISH))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take_out)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg   <= dst_next;
        src_reg   <= src_next;
        blank_reg <= blank_next;
        down_reg  <= down_next;
        if (accept && in_data.func)
        begin
            rd_ok_reg <= ({1'b0, in_data.read_row} <= (ROW_W)'(TR))
                         && (in_data.read_col < TC);
        end
        if (accept && !in_data.func && (pr.cmd == CMD_NONE))
        begin
            out_reg.cursor_row_out <= pr.row[4:0];
            out_reg.cursor_col_out <= pr.col;
            out_reg.cell_char      <= '0;
        end
        else if (state_reg == ST_RD_WAIT)
        begin
            out_reg.cursor_row_out <= row_reg[4:0];
            out_reg.cursor_col_out <= col_reg;
            out_reg.cell_char      <= rd_ok_reg ? ram_rdata : 8'h00;
        end
        else if (state_reg == ST_FINISH)
        begin
            out_reg.cursor_row_out <= row_reg[4:0];
            out_reg.cursor_col_out <= col_reg;
            out_reg.cell_char      <= '0;
        end
    end
endmodule
